[rtl/msc_pkg.sv]
// ----------------------------------------------------------------------------
// msc_pkg
// Shared constants for the shortest-column masonry placer: field widths,
// configuration register indexes, saturation limits and default sizes.
// ----------------------------------------------------------------------------
package msc_pkg;

  // Default sizing of the column store
  localparam int MAX_COLUMNS_DEF = 16;
  localparam int HEIGHT_BITS_DEF = 24;

  // Transaction field widths
  localparam int KIND_W   = 1;
  localparam int ITEM_W   = 20;
  localparam int COLOUT_W = 4;
  localparam int X_W      = 20;
  localparam int Y_W      = 24;

  // Configuration port
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int COL_COUNT_W = 5;
  localparam int LEN_W       = 16;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_PITCH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_AXIS_GAP  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_HEIGHT = 2'd3;

  // Transaction kinds
  localparam logic KIND_CLEAR = 1'b0;
  localparam logic KIND_PLACE = 1'b1;

  // Output saturation limits
  localparam logic [X_W-1:0] X_MAX = {X_W{1'b1}};
  localparam logic [Y_W-1:0] Y_MAX = {Y_W{1'b1}};

endpackage

[rtl/msc_if.sv]
// ----------------------------------------------------------------------------
// msc_in_if / msc_out_if
// Valid/ready channels for placer requests and placement results.
// ----------------------------------------------------------------------------
interface msc_in_if;
  logic                       valid;
  logic                       ready;
  logic [msc_pkg::KIND_W-1:0] kind;
  logic [msc_pkg::ITEM_W-1:0] item_height;
  logic                       height_known;

  modport source (output valid, output kind, output item_height, output height_known,
                  input ready);
  modport sink   (input valid, input kind, input item_height, input height_known,
                  output ready);
endinterface

interface msc_out_if;
  logic                         valid;
  logic                         ready;
  logic [msc_pkg::COLOUT_W-1:0] column;
  logic [msc_pkg::X_W-1:0]      offset_x;
  logic [msc_pkg::Y_W-1:0]      offset_y;
  logic [msc_pkg::Y_W-1:0]      content_extent;
  logic                         saturated;

  modport source (output valid, output column, output offset_x, output offset_y,
                  output content_extent, output saturated, input ready);
  modport sink   (input valid, input column, input offset_x, input offset_y,
                  input content_extent, input saturated, output ready);
endinterface

[rtl/msc_select.sv]
// ----------------------------------------------------------------------------
// msc_select
// Balanced compare tree over the columns in use: finds the shortest column
// (lowest index on a tie) and the tallest column height.
// ----------------------------------------------------------------------------
module msc_select #(
  parameter int NCOL = msc_pkg::MAX_COLUMNS_DEF,
  parameter int HB   = msc_pkg::HEIGHT_BITS_DEF,
  parameter int CW   = 4,
  parameter int CNTW = 5
) (
  input  logic [HB-1:0]   heights [NCOL],
  input  logic [CNTW-1:0] n_used,
  output logic [CW-1:0]   best_idx,
  output logic [HB-1:0]   best_h,
  output logic [HB-1:0]   top_h
);

  localparam int NPAD = 1 << CW;

  logic [HB-1:0] min_h [2*NPAD];
  logic [CW-1:0] min_i [2*NPAD];
  logic          min_v [2*NPAD];
  logic [HB-1:0] max_h [2*NPAD];

  always_comb begin
    // leaves: columns past the count (and padding) are not candidates
    for (int k = 0; k < 2*NPAD; k++) begin
      min_h[k] = '0;
      min_i[k] = '0;
      min_v[k] = 1'b0;
      max_h[k] = '0;
    end
    for (int c = 0; c < NPAD; c++) begin
      min_i[NPAD+c] = CW'(c);
      if (c < NCOL) begin
        if (CNTW'(c) < n_used) begin
          min_h[NPAD+c] = heights[c];
          min_v[NPAD+c] = 1'b1;
          max_h[NPAD+c] = heights[c];
        end
      end
    end
    // inner nodes: left wins on a tie to keep the lower index
    for (int k = NPAD-1; k >= 1; k--) begin
      if (min_v[2*k] && (!min_v[2*k+1] || (min_h[2*k] <= min_h[2*k+1]))) begin
        min_h[k] = min_h[2*k];
        min_i[k] = min_i[2*k];
        min_v[k] = 1'b1;
      end else begin
        min_h[k] = min_h[2*k+1];
        min_i[k] = min_i[2*k+1];
        min_v[k] = min_v[2*k+1];
      end
      max_h[k] = (max_h[2*k] >= max_h[2*k+1]) ? max_h[2*k] : max_h[2*k+1];
    end
  end

  assign best_idx = min_i[1];
  assign best_h   = min_h[1];
  assign top_h    = max_h[1];

endmodule

[rtl/masonry_shortest_column_placer_top.sv]
// ----------------------------------------------------------------------------
// masonry_shortest_column_placer_top
// A request is held in the request register, and its result then in the result register.
// Throughput: one transaction per cycle unless out_chan stalls; the compare tree, height sum,
// x multiply and column register update sit between the request and result registers.
// Reset (synchronous, rst_n low): all column heights to zero, column_count 1,
// other configuration registers zero, both pipeline registers empty.
// ----------------------------------------------------------------------------
module masonry_shortest_column_placer_top #(
  parameter int MAX_COLUMNS = msc_pkg::MAX_COLUMNS_DEF,
  parameter int HEIGHT_BITS = msc_pkg::HEIGHT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [msc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [msc_pkg::CFG_DATA_W-1:0]   cfg_data,
  msc_in_if.sink                           in_chan,
  msc_out_if.source                        out_chan
);

  localparam int CW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNTW = $clog2(MAX_COLUMNS + 1);
  localparam int GW   = ((HEIGHT_BITS > msc_pkg::ITEM_W) ? HEIGHT_BITS
                                                         : msc_pkg::ITEM_W) + 2;
  localparam int YW   = (HEIGHT_BITS > msc_pkg::Y_W) ? HEIGHT_BITS : msc_pkg::Y_W;
  localparam int XW   = CW + msc_pkg::LEN_W;
  localparam int XEW  = (XW > msc_pkg::X_W) ? XW : msc_pkg::X_W;
  localparam logic [GW-1:0] HEIGHT_MAX = GW'({HEIGHT_BITS{1'b1}});

  // configuration registers
  logic [msc_pkg::COL_COUNT_W-1:0] column_count_r;
  logic [msc_pkg::LEN_W-1:0]       column_pitch_r;
  logic [msc_pkg::LEN_W-1:0]       main_axis_gap_r;
  logic [msc_pkg::LEN_W-1:0]       unknown_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r   <= msc_pkg::COL_COUNT_W'(1);
      column_pitch_r   <= '0;
      main_axis_gap_r  <= '0;
      unknown_height_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        msc_pkg::REG_COLUMN_COUNT:   column_count_r   <= cfg_data[msc_pkg::COL_COUNT_W-1:0];
        msc_pkg::REG_COLUMN_PITCH:   column_pitch_r   <= cfg_data;
        msc_pkg::REG_MAIN_AXIS_GAP:  main_axis_gap_r  <= cfg_data;
        msc_pkg::REG_UNKNOWN_HEIGHT: unknown_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // request register and handshake
  logic                        stage_v_r;
  logic                        stage_kind_r;
  logic [msc_pkg::ITEM_W-1:0]  stage_item_r;
  logic                        stage_known_r;
  logic                        out_valid_r;
  logic                        advance;
  logic                        fire;
  logic                        in_accept;

  assign advance       = !out_valid_r || out_chan.ready;
  assign fire          = stage_v_r && advance;
  assign in_chan.ready = !stage_v_r || advance;
  assign in_accept     = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (in_accept) begin
      stage_v_r <= 1'b1;
    end else if (fire) begin
      stage_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage_kind_r  <= in_chan.kind;
      stage_item_r  <= in_chan.item_height;
      stage_known_r <= in_chan.height_known;
    end
  end

  // columns in use: zero means one, clamp at the store depth
  logic [CNTW-1:0] n_used;
  always_comb begin
    if (column_count_r == '0) begin
      n_used = CNTW'(1);
    end else if (32'(column_count_r) > MAX_COLUMNS) begin
      n_used = CNTW'(MAX_COLUMNS);
    end else begin
      n_used = CNTW'(column_count_r);
    end
  end

  // column heights and compare tree
  logic [HEIGHT_BITS-1:0] heights_r [MAX_COLUMNS];
  logic [CW-1:0]          best_idx;
  logic [HEIGHT_BITS-1:0] best_h;
  logic [HEIGHT_BITS-1:0] top_h;

  msc_select #(
    .NCOL (MAX_COLUMNS),
    .HB   (HEIGHT_BITS),
    .CW   (CW),
    .CNTW (CNTW)
  ) u_select (
    .heights  (heights_r),
    .n_used   (n_used),
    .best_idx (best_idx),
    .best_h   (best_h),
    .top_h    (top_h)
  );

  // placement arithmetic
  logic [msc_pkg::ITEM_W-1:0]  item_eff;
  logic [GW-1:0]               grown_raw;
  logic [HEIGHT_BITS-1:0]      grown;
  logic                        clipped;
  logic [XW-1:0]               x_raw;
  logic [XEW-1:0]              x_ext;
  logic [msc_pkg::X_W-1:0]     x_sat;
  logic [YW-1:0]               y_ext;
  logic [msc_pkg::Y_W-1:0]     y_sat;
  logic [HEIGHT_BITS-1:0]      top_new;
  logic [HEIGHT_BITS-1:0]      top_less_gap;
  logic [YW-1:0]               ext_ext;
  logic [msc_pkg::Y_W-1:0]     ext_sat;

  always_comb begin
    item_eff  = stage_known_r ? stage_item_r : msc_pkg::ITEM_W'(unknown_height_r);
    grown_raw = GW'(best_h) + GW'(item_eff) + GW'(main_axis_gap_r);
    clipped   = grown_raw > HEIGHT_MAX;
    grown     = clipped ? HEIGHT_MAX[HEIGHT_BITS-1:0] : grown_raw[HEIGHT_BITS-1:0];

    x_raw = XW'(best_idx) * XW'(column_pitch_r);
    x_ext = XEW'(x_raw);
    x_sat = (x_ext > XEW'(msc_pkg::X_MAX)) ? msc_pkg::X_MAX : x_ext[msc_pkg::X_W-1:0];

    y_ext = YW'(best_h);
    y_sat = (y_ext > YW'(msc_pkg::Y_MAX)) ? msc_pkg::Y_MAX : y_ext[msc_pkg::Y_W-1:0];

    // only the chosen column changes and it never shrinks
    top_new      = (grown > top_h) ? grown : top_h;
    top_less_gap = (top_new > HEIGHT_BITS'(main_axis_gap_r))
                   ? top_new - HEIGHT_BITS'(main_axis_gap_r) : '0;
    ext_ext      = YW'(top_less_gap);
    ext_sat      = (ext_ext > YW'(msc_pkg::Y_MAX)) ? msc_pkg::Y_MAX
                                                   : ext_ext[msc_pkg::Y_W-1:0];
  end

  // column height update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < MAX_COLUMNS; c++) begin
        heights_r[c] <= '0;
      end
    end else if (fire) begin
      if (stage_kind_r == msc_pkg::KIND_CLEAR) begin
        for (int c = 0; c < MAX_COLUMNS; c++) begin
          heights_r[c] <= '0;
        end
      end else begin
        heights_r[best_idx] <= grown;
      end
    end
  end

  // result register
  logic [msc_pkg::COLOUT_W-1:0] column_r;
  logic [msc_pkg::X_W-1:0]      offset_x_r;
  logic [msc_pkg::Y_W-1:0]      offset_y_r;
  logic [msc_pkg::Y_W-1:0]      extent_r;
  logic                         saturated_r;
  logic [CW+msc_pkg::COLOUT_W-1:0] best_wide;

  assign best_wide = (CW+msc_pkg::COLOUT_W)'(best_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (stage_kind_r == msc_pkg::KIND_CLEAR) begin
        column_r    <= '0;
        offset_x_r  <= '0;
        offset_y_r  <= '0;
        extent_r    <= '0;
        saturated_r <= 1'b0;
      end else begin
        column_r    <= best_wide[msc_pkg::COLOUT_W-1:0];
        offset_x_r  <= x_sat;
        offset_y_r  <= y_sat;
        extent_r    <= ext_sat;
        saturated_r <= clipped;
      end
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.column         = column_r;
  assign out_chan.offset_x       = offset_x_r;
  assign out_chan.offset_y       = offset_y_r;
  assign out_chan.content_extent = extent_r;
  assign out_chan.saturated      = saturated_r;

`ifndef SYNTHESIS
  // a clear transaction leaves the first column at zero
  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (stage_kind_r == msc_pkg::KIND_CLEAR) |=> heights_r[0] == '0)
    else $error("column height not cleared");

  // a clipped placement leaves the chosen column at its maximum
  a_clip_holds_max: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (stage_kind_r == msc_pkg::KIND_PLACE) && clipped
    |=> heights_r[$past(best_idx)] == HEIGHT_MAX[HEIGHT_BITS-1:0])
    else $error("clipped column not held at maximum");

  // a held request is not dropped while the result side stalls
  a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
    stage_v_r && !advance |=> stage_v_r)
    else $error("request lost during stall");

  // offset_y of an unclipped placement never exceeds the reported extent plus one gap
  a_y_in_extent: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (stage_kind_r == msc_pkg::KIND_PLACE) && !clipped
    |-> (YW+1)'(y_sat) <= (YW+1)'(ext_sat) + (YW+1)'(main_axis_gap_r))
    else $error("offset_y above content extent");
`endif

endmodule
